@@ hdl/tet_pkg.sv @@
// Shared types, constants and the microcode table for the tricorn escape-time engine.
// Depends on nothing; used by tet_seq, tet_dp, tricorn_escape_time, tet_escape_checker and the testbench.
package tet_pkg;

  localparam int unsigned PC_W = 3;

  // configuration register indexes
  localparam logic [1:0] REG_PIXEL_STEP = 2'd0;
  localparam logic [1:0] REG_ORIGIN_RE  = 2'd1;
  localparam logic [1:0] REG_ORIGIN_IM  = 2'd2;
  localparam logic [1:0] REG_MAX_ITER   = 2'd3;

  localparam logic [34:0] PIXEL_STEP_RST = 35'd1073741;
  localparam logic signed [35:0] ORIGIN_RST = -36'sd536870912;
  localparam logic [15:0] MAX_ITER_RST = 16'd50;

  // |x| < 2.0 in Q8.28, and 4.0 in Q16.56 for the exact magnitude test
  localparam logic signed [35:0] TWO_Q = 36'sd536870912;
  localparam logic [60:0] FOUR_SQ = 61'd1 << 58;

  // microcode step addresses
  localparam logic [PC_W-1:0] UC_IDLE = 3'd0;
  localparam logic [PC_W-1:0] UC_MUL_CRE = 3'd1;
  localparam logic [PC_W-1:0] UC_LD_CRE = 3'd2;
  localparam logic [PC_W-1:0] UC_LD_CIM = 3'd3;
  localparam logic [PC_W-1:0] UC_LOOP = 3'd4;
  localparam logic [PC_W-1:0] UC_MUL_II = 3'd5;
  localparam logic [PC_W-1:0] UC_MUL_RI = 3'd6;
  localparam logic [PC_W-1:0] UC_UPDATE = 3'd7;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_C_RE,
    MUL_C_IM,
    MUL_RR,
    MUL_II,
    MUL_RI
  } mul_sel_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_IDLE,
    COND_EXIT
  } cond_t;

  typedef struct packed {
    mul_sel_t        mul_sel;
    logic            ld_init;
    logic            ld_cre;
    logic            ld_cim;
    logic            lat_rr;
    logic            lat_ii;
    logic            upd;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic [PC_W-1:0] nxt;
  } uword_t;

  typedef struct packed {
    logic exit;
  } stat_t;

  typedef struct packed {
    logic [9:0] pixel_col;
    logic [9:0] pixel_row;
  } pix_t;

  typedef struct packed {
    logic [9:0]         out_col;
    logic [9:0]         out_row;
    logic [15:0]        iter_count;
    logic               escaped;
    logic signed [35:0] z_sum;
  } res_t;

  // microprogram: jump to target when the step's condition holds, else go to nxt
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{mul_sel: MUL_NONE, ld_init: 1'b0, ld_cre: 1'b0, ld_cim: 1'b0, lat_rr: 1'b0,
          lat_ii: 1'b0, upd: 1'b0, cond: COND_NONE, target: UC_IDLE, nxt: UC_IDLE};
    case (pc)
      UC_IDLE: begin
        w.ld_init = 1'b1;
        w.cond    = COND_IDLE;
        w.target  = UC_IDLE;
        w.nxt     = UC_MUL_CRE;
      end
      UC_MUL_CRE: begin
        w.mul_sel = MUL_C_RE;
        w.nxt     = UC_LD_CRE;
      end
      UC_LD_CRE: begin
        w.ld_cre  = 1'b1;
        w.mul_sel = MUL_C_IM;
        w.nxt     = UC_LD_CIM;
      end
      UC_LD_CIM: begin
        w.ld_cim = 1'b1;
        w.nxt    = UC_LOOP;
      end
      UC_LOOP: begin
        w.mul_sel = MUL_RR;
        w.nxt     = UC_MUL_II;
      end
      UC_MUL_II: begin
        w.lat_rr  = 1'b1;
        w.mul_sel = MUL_II;
        w.nxt     = UC_MUL_RI;
      end
      UC_MUL_RI: begin
        w.lat_ii  = 1'b1;
        w.mul_sel = MUL_RI;
        w.nxt     = UC_UPDATE;
      end
      UC_UPDATE: begin
        w.upd    = 1'b1;
        w.cond   = COND_EXIT;
        w.target = UC_IDLE;
        w.nxt    = UC_LOOP;
      end
      default: begin
        w.nxt = UC_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [35:0] sat36(input logic signed [47:0] v);
    logic signed [35:0] r;
    if (v > 48'sh0007FFFFFFFF) begin
      r = 36'sh7FFFFFFFF;
    end else if (v < -48'sh000800000000) begin
      r = 36'sh800000000;
    end else begin
      r = v[35:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/tet_seq.sv @@
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on tet_pkg.
module tet_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  tet_pkg::stat_t  st,
  output tet_pkg::uword_t ctl,
  output logic            busy
);

  logic [tet_pkg::PC_W-1:0] pc;
  logic [tet_pkg::PC_W-1:0] pc_next;
  tet_pkg::uword_t          w;
  logic                     jump;

  always_comb begin
    w = tet_pkg::ucode(pc);
    case (w.cond)
      tet_pkg::COND_NONE: jump = 1'b0;
      tet_pkg::COND_IDLE: jump = !start;
      tet_pkg::COND_EXIT: jump = st.exit;
      default:            jump = 1'b0;
    endcase
    pc_next = jump ? w.target : w.nxt;
    ctl = w;
    // a pixel beat is taken only when start is up in the idle step
    ctl.ld_init = w.ld_init & start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= tet_pkg::UC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign busy = (pc != tet_pkg::UC_IDLE);

endmodule

@@ hdl/tet_dp.sv @@
// Datapath: shared 36x30 multiplier, point mapping, z update, escape test, result register.
// Depends on tet_pkg; driven by the control word from tet_seq.
module tet_dp (
  input  logic               clk,
  input  logic               rst,
  input  tet_pkg::uword_t    ctl,
  input  tet_pkg::pix_t      pixel,
  input  logic [34:0]        pixel_step,
  input  logic signed [35:0] origin_re,
  input  logic signed [35:0] origin_im,
  input  logic [15:0]        max_iter,
  output tet_pkg::stat_t     st,
  output logic               done,
  output tet_pkg::res_t      result
);

  logic [9:0]         col;
  logic [9:0]         row;
  logic signed [35:0] c_re;
  logic signed [35:0] c_im;
  logic signed [35:0] re;
  logic signed [35:0] im;
  logic [15:0]        n;
  logic signed [65:0] prod;
  logic [59:0]        p_rr;
  logic [59:0]        p_ii;

  logic signed [35:0] ma;
  logic signed [29:0] mb;
  logic signed [47:0] c_sum;
  logic signed [65:0] nprod;
  logic signed [32:0] rr;
  logic signed [32:0] ii;
  logic signed [32:0] neg_ri;
  logic signed [35:0] re_next;
  logic signed [35:0] im_next;
  logic [60:0]        mag;
  logic               re_small;
  logic               im_small;
  logic               bounded;
  logic               emit;

  always_comb begin
    case (ctl.mul_sel)
      tet_pkg::MUL_C_RE: begin
        ma = $signed({1'b0, pixel_step});
        mb = $signed({20'd0, col});
      end
      tet_pkg::MUL_C_IM: begin
        ma = $signed({1'b0, pixel_step});
        mb = $signed({20'd0, row});
      end
      tet_pkg::MUL_RR: begin
        ma = 36'($signed(re[29:0]));
        mb = $signed(re[29:0]);
      end
      tet_pkg::MUL_II: begin
        ma = 36'($signed(im[29:0]));
        mb = $signed(im[29:0]);
      end
      tet_pkg::MUL_RI: begin
        ma = 36'($signed(re[29:0]));
        mb = $signed(im[29:0]);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // c = pixel * step + origin; the product is below 2^45
  assign c_sum = 48'($signed(prod[45:0])) + (ctl.ld_cre ? 48'(origin_re) : 48'(origin_im));

  // floor shifts; operands are in range only while |re|,|im| < 2
  assign rr      = $signed({1'b0, p_rr[59:28]});
  assign ii      = $signed({1'b0, p_ii[59:28]});
  assign nprod   = -prod;
  assign neg_ri  = $signed(nprod[59:27]);
  assign re_next = tet_pkg::sat36(48'(rr) - 48'(ii) + 48'(c_re));
  assign im_next = tet_pkg::sat36(48'(neg_ri) + 48'(c_im));

  assign re_small = (re < tet_pkg::TWO_Q) && (re > -tet_pkg::TWO_Q);
  assign im_small = (im < tet_pkg::TWO_Q) && (im > -tet_pkg::TWO_Q);
  assign mag      = {1'b0, p_rr} + {1'b0, p_ii};
  assign bounded  = re_small && im_small && (mag < tet_pkg::FOUR_SQ);

  assign st.exit = !bounded || (n >= max_iter);
  assign emit    = ctl.upd && st.exit;

  always_ff @(posedge clk) begin
    prod <= 66'(ma) * 66'(mb);
    if (ctl.lat_rr) begin
      p_rr <= prod[59:0];
    end
    if (ctl.lat_ii) begin
      p_ii <= prod[59:0];
    end
    if (ctl.ld_cre) begin
      c_re <= tet_pkg::sat36(c_sum);
    end
    if (ctl.ld_cim) begin
      c_im <= tet_pkg::sat36(c_sum);
    end
    if (ctl.ld_init) begin
      col <= pixel.pixel_col;
      row <= pixel.pixel_row;
      re  <= '0;
      im  <= '0;
      n   <= '0;
    end else if (ctl.upd && !st.exit) begin
      re <= re_next;
      im <= im_next;
      n  <= n + 16'd1;
    end
    if (emit) begin
      result.out_col    <= col;
      result.out_row    <= row;
      result.iter_count <= n;
      result.escaped    <= !bounded;
      result.z_sum      <= tet_pkg::sat36(48'(re) + 48'(im));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= emit;
    end
  end

endmodule

@@ hdl/tricorn_escape_time.sv @@
// Tricorn escape-time engine: one pixel in, one result beat out.
// Per pixel the sequencer first maps c_re and c_im on the shared multiplier, then loops;
// each iteration runs re^2, im^2 and re*im in turn on the one shared multiplier, then the update.
// A new pixel waits until the last one is done; start is taken again in the done cycle.
// Result is a single-cycle done strobe; the receiver cannot stall it.
// Synchronous active-high rst clears the sequencer and strobe and loads register defaults.
module tricorn_escape_time (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  tet_pkg::pix_t  pixel,
  output logic           done,
  output tet_pkg::res_t  result,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [35:0]    cfg_data
);

  logic [34:0]        pixel_step;
  logic signed [35:0] origin_re;
  logic signed [35:0] origin_im;
  logic [15:0]        max_iter;

  tet_pkg::uword_t ctl;
  tet_pkg::stat_t  st;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_step <= tet_pkg::PIXEL_STEP_RST;
      origin_re  <= tet_pkg::ORIGIN_RST;
      origin_im  <= tet_pkg::ORIGIN_RST;
      max_iter   <= tet_pkg::MAX_ITER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tet_pkg::REG_PIXEL_STEP: pixel_step <= cfg_data[34:0];
        tet_pkg::REG_ORIGIN_RE:  origin_re  <= $signed(cfg_data);
        tet_pkg::REG_ORIGIN_IM:  origin_im  <= $signed(cfg_data);
        tet_pkg::REG_MAX_ITER:   max_iter   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  tet_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .ctl   (ctl),
    .busy  (busy)
  );

  tet_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .pixel      (pixel),
    .pixel_step (pixel_step),
    .origin_re  (origin_re),
    .origin_im  (origin_im),
    .max_iter   (max_iter),
    .st         (st),
    .done       (done),
    .result     (result)
  );

endmodule

@@ dv/tet_escape_checker.sv @@
`timescale 1ns / 100ps
// Checker for tricorn_escape_time: tracks the register writes, predicts each result beat.
// Compares beats field by field in order. Depends on tet_pkg.
module tet_escape_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  tet_pkg::pix_t  pixel,
  input  logic           done,
  input  tet_pkg::res_t  result,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [35:0]    cfg_data,
  output int unsigned    errors,
  output int unsigned    pending
);

  localparam logic signed [47:0] Q_HI = (48'sd1 <<< 35) - 48'sd1;
  localparam logic signed [47:0] Q_LO = -(48'sd1 <<< 35);
  // 4.0 at the scale of a full Q8.28 product
  localparam logic signed [71:0] MAG_FOUR = 72'sd1 <<< 58;

  logic [34:0]        step_q;
  logic signed [35:0] org_re;
  logic signed [35:0] org_im;
  logic [15:0]        iter_limit;
  tet_pkg::res_t      expected_q[$];

  function automatic logic signed [35:0] clamp_q(input logic signed [47:0] v);
    if (v > Q_HI) begin
      return Q_HI[35:0];
    end
    if (v < Q_LO) begin
      return Q_LO[35:0];
    end
    return v[35:0];
  endfunction

  // exact test of re^2 + im^2 < 4; a part at or beyond 2 escapes outright
  function automatic bit below_two(input logic signed [35:0] re, input logic signed [35:0] im);
    logic signed [71:0] mag;
    if (re >= tet_pkg::TWO_Q || re <= -tet_pkg::TWO_Q ||
        im >= tet_pkg::TWO_Q || im <= -tet_pkg::TWO_Q) begin
      return 1'b0;
    end
    mag = 72'(re) * 72'(re) + 72'(im) * 72'(im);
    return mag < MAG_FOUR;
  endfunction

  function automatic tet_pkg::res_t escape_pixel(input tet_pkg::pix_t px);
    logic signed [35:0] c_re, c_im, re, im;
    logic signed [47:0] rr, ii, xx;
    logic signed [71:0] prod;
    int unsigned n;
    tet_pkg::res_t r;
    c_re = clamp_q($signed({38'd0, px.pixel_col}) * $signed({13'd0, step_q}) + 48'(org_re));
    c_im = clamp_q($signed({38'd0, px.pixel_row}) * $signed({13'd0, step_q}) + 48'(org_im));
    re = '0;
    im = '0;
    n = 0;
    while (n < iter_limit && below_two(re, im)) begin
      // arithmetic shift right is floor division by 2^28
      prod = 72'(re) * 72'(re);
      rr = 48'(prod >>> 28);
      prod = 72'(im) * 72'(im);
      ii = 48'(prod >>> 28);
      prod = 72'(re) * 72'(im);
      prod = -(prod <<< 1);
      xx = 48'(prod >>> 28);
      re = clamp_q(rr - ii + 48'(c_re));
      im = clamp_q(xx + 48'(c_im));
      n++;
    end
    r.out_col    = px.pixel_col;
    r.out_row    = px.pixel_row;
    r.iter_count = 16'(n);
    r.escaped    = !below_two(re, im);
    r.z_sum      = clamp_q(48'(re) + 48'(im));
    return r;
  endfunction

  task automatic compare_field(input string name, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    tet_pkg::res_t want;
    if (rst) begin
      step_q     = tet_pkg::PIXEL_STEP_RST;
      org_re     = tet_pkg::ORIGIN_RST;
      org_im     = tet_pkg::ORIGIN_RST;
      iter_limit = tet_pkg::MAX_ITER_RST;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tet_pkg::REG_PIXEL_STEP: step_q = cfg_data[34:0];
          tet_pkg::REG_ORIGIN_RE:  org_re = cfg_data;
          tet_pkg::REG_ORIGIN_IM:  org_im = cfg_data;
          tet_pkg::REG_MAX_ITER:   iter_limit = cfg_data[15:0];
          default: ;
        endcase
      end
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no pixel outstanding");
          errors++;
        end else begin
          want = expected_q.pop_front();
          compare_field("out_col", want.out_col, result.out_col);
          compare_field("out_row", want.out_row, result.out_row);
          compare_field("iter_count", want.iter_count, result.iter_count);
          compare_field("escaped", want.escaped, result.escaped);
          compare_field("z_sum", $signed(want.z_sum), $signed(result.z_sum));
        end
      end
      if (start && !busy) begin
        expected_q.push_back(escape_pixel(pixel));
      end
    end
    pending = expected_q.size();
  end

endmodule

@@ dv/tb_tricorn_escape_time.sv @@
`timescale 1ns / 100ps
// Testbench top for tricorn_escape_time: clock, reset, register phases and pixel stimulus.
// Depends on tet_pkg, the block and tet_escape_checker, which does all result checking.
module tb_tricorn_escape_time;

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  tet_pkg::pix_t pixel;
  logic          done;
  tet_pkg::res_t result;
  logic          cfg_we;
  logic [1:0]    cfg_index;
  logic [35:0]   cfg_data;
  int unsigned   errors;
  int unsigned   pending;

  tricorn_escape_time dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel     (pixel),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tet_escape_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel     (pixel),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // only called with no pixel in flight
  task automatic set_regs(input logic [34:0] step, input logic signed [35:0] re0,
                          input logic signed [35:0] im0, input logic [15:0] lim);
    logic [35:0] vals[4];
    vals[tet_pkg::REG_PIXEL_STEP] = {1'b0, step};
    vals[tet_pkg::REG_ORIGIN_RE]  = re0;
    vals[tet_pkg::REG_ORIGIN_IM]  = im0;
    vals[tet_pkg::REG_MAX_ITER]   = {20'd0, lim};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we    = 1'b1;
      cfg_index = 2'(i);
      cfg_data  = vals[i];
    end
    @(negedge clk);
    cfg_we   = 1'b0;
    cfg_data = {4'($urandom_range(0, 15)), 32'($urandom)};
  endtask

  task automatic send_pixel(input logic [9:0] col, input logic [9:0] row);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      gap = 0;
    end else if (pick < 90) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(10, 40);
    end
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
      pixel = 20'($urandom);
    end
    @(negedge clk);
    start = 1'b1;
    pixel = '{pixel_col: col, pixel_row: row};
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : stim
    logic [34:0]        step;
    logic signed [35:0] re0, im0;
    logic [15:0]        lim;
    start     = 1'b0;
    pixel     = '0;
    cfg_we    = 1'b0;
    cfg_index = tet_pkg::REG_PIXEL_STEP;
    cfg_data  = '0;
    rst       = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset register values
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd341, 10'd682);
    wait_idle();

    // zero limit: no iteration at all
    set_regs(35'd1073741, -36'sd536870912, -36'sd536870912, 16'd0);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    wait_idle();

    // zero step at the origin, c = 0 never escapes: runs the full limit
    set_regs(35'd0, 36'sd0, 36'sd0, 16'hFFFF);
    send_pixel(10'd1023, 10'd1023);
    wait_idle();

    // largest step with extreme origins: c spans both ends of the range and saturates at the top
    set_regs({35{1'b1}}, (36'sd1 <<< 35) - 36'sd1, -(36'sd1 <<< 35), 16'hFFFF);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd1, 10'd1);
    wait_idle();

    // c = -2 escapes on the only allowed iteration
    set_regs(35'd0, -36'sd536870912, 36'sd0, 16'd1);
    send_pixel(10'd5, 10'd7);
    send_pixel(10'd1023, 10'd1023);
    wait_idle();

    // c = 1 reaches |z| = 2 exactly on the second and last iteration
    set_regs(35'd0, 36'sd268435456, 36'sd0, 16'd2);
    send_pixel(10'd3, 10'd3);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) begin
        step = {3'($urandom_range(0, 7)), 32'($urandom)};
        re0  = {4'($urandom_range(0, 15)), 32'($urandom)};
        im0  = {4'($urandom_range(0, 15)), 32'($urandom)};
      end else begin
        // windows around the interesting part of the plane, origins in -3.0 .. 1.0
        step = 35'($urandom_range(1 << 18, 1 << 22));
        re0  = -36'sd805306368 + $signed(36'($urandom_range(0, 1073741824)));
        im0  = -36'sd805306368 + $signed(36'($urandom_range(0, 1073741824)));
      end
      lim = 16'($urandom_range(1, 64));
      set_regs(step, re0, im0, lim);
      for (int k = 0; k < 118; k++) begin
        send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
      end
      wait_idle();
    end

    repeat (300) @(negedge clk);
    if (errors == 0) begin
      $display("tricorn_escape_time: match");
    end else begin
      $display("tricorn_escape_time: mismatch");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("tricorn_escape_time: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/tet_pkg.sv
hdl/tet_seq.sv
hdl/tet_dp.sv
hdl/tricorn_escape_time.sv
dv/tet_escape_checker.sv
dv/tb_tricorn_escape_time.sv
